[rtl/fsst_pkg.sv]
// shared types and constants for the frame sync and shutter timing unit
package fsst_pkg;

   // sensor sample width and the step count at which an armed offset forces opening
   localparam int SAMPLE_BITS  = 10;
   localparam int OFFSET_LIMIT = 128;

   localparam int OFFSET_BITS = 7;
   localparam int THRESH_BITS = 10;
   localparam int COUNT_BITS  = 16;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;

   // offset counter wide enough to hold the limit itself
   localparam int OFS_CNT_BITS = $clog2(OFFSET_LIMIT + 1);

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MID = SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));
   localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = '1;

   typedef logic [CSR_IDX_BITS-1:0] csr_idx_type;

   // register indexes of the configuration port
   localparam csr_idx_type CSR_OFFSET_STEPS   = 3'd0;
   localparam csr_idx_type CSR_DIFF_THRESHOLD = 3'd1;
   localparam csr_idx_type CSR_LOW_TRIGGER    = 3'd2;
   localparam csr_idx_type CSR_MIN_STEPS      = 3'd3;
   localparam csr_idx_type CSR_OPEN_TIME      = 3'd4;
   localparam csr_idx_type CSR_SHUTTER_ENABLE = 3'd5;

   // item kinds
   localparam logic FUNC_STEP = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   typedef struct packed {
      logic [OFFSET_BITS-1:0] offset_steps;
      logic [THRESH_BITS-1:0] diff_threshold;
      logic [THRESH_BITS-1:0] low_trigger;
      logic [COUNT_BITS-1:0]  min_steps;
      logic [COUNT_BITS-1:0]  open_time;
      logic                   shutter_enable;
   } cfg_type;

   typedef struct packed {
      logic shutter_open;
      logic hole_seen;
      logic opened_now;
   } result_type;

endpackage

[rtl/frame_sync_shutter_timing_unit.sv]
// top level of the frame sync and shutter timing unit
//
// Takes one transaction per cycle while the response queue has room: each
// request is a motor step with a sensor sample or a millisecond tick, and
// yields exactly one response with the shutter state, a hole-detected flag and
// an opened flag. The state update is combinational logic on the accepted
// request, and the response sits in a two-entry queue, so a request is taken
// whenever that queue has a free slot. Configuration writes are always taken,
// one per cycle, and must only be made while the unit is idle.
module frame_sync_shutter_timing_unit
   import fsst_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_func,
   input  logic [SAMPLE_BITS-1:0]   req_sample,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_shutter_open,
   output logic                     rsp_hole_seen,
   output logic                     rsp_opened_now,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cfg_type    cfg_ff;
   result_type core_result;
   result_type buf_data;
   logic       buf_full;
   logic       accept;

   assign csr_ready = 1'b1;
   assign req_ready = !buf_full;
   assign accept    = req_valid && req_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_steps   <= '0;
         cfg_ff.diff_threshold <= THRESH_BITS'(100);
         cfg_ff.low_trigger    <= THRESH_BITS'(300);
         cfg_ff.min_steps      <= COUNT_BITS'(20);
         cfg_ff.open_time      <= COUNT_BITS'(20);
         cfg_ff.shutter_enable <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_OFFSET_STEPS:   cfg_ff.offset_steps   <= csr_wdata[OFFSET_BITS-1:0];
            CSR_DIFF_THRESHOLD: cfg_ff.diff_threshold <= csr_wdata[THRESH_BITS-1:0];
            CSR_LOW_TRIGGER:    cfg_ff.low_trigger    <= csr_wdata[THRESH_BITS-1:0];
            CSR_MIN_STEPS:      cfg_ff.min_steps      <= csr_wdata[COUNT_BITS-1:0];
            CSR_OPEN_TIME:      cfg_ff.open_time      <= csr_wdata[COUNT_BITS-1:0];
            CSR_SHUTTER_ENABLE: cfg_ff.shutter_enable <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // state update
   fsst_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .func   (req_func),
      .sample (req_sample),
      .cfg    (cfg_ff),
      .result (core_result)
   );

   // response queue
   fsst_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (core_result),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (buf_data)
   );

   assign rsp_shutter_open = buf_data.shutter_open;
   assign rsp_hole_seen    = buf_data.hole_seen;
   assign rsp_opened_now   = buf_data.opened_now;

endmodule

[rtl/fsst_core.sv]
// per-item state update: hole detection, offset counter and open timer
module fsst_core
   import fsst_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   func,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  cfg_type                cfg,
   output result_type             result
);

   localparam int CMP_W = (SAMPLE_BITS > THRESH_BITS ? SAMPLE_BITS : THRESH_BITS) + 2;
   localparam int OFS_CMP_W = OFS_CNT_BITS > OFFSET_BITS ? OFS_CNT_BITS : OFFSET_BITS;

   logic [SAMPLE_BITS-1:0]  prev_sample_ff, prev_sample_in;
   logic [SAMPLE_BITS-1:0]  older_sample_ff, older_sample_in;
   logic [COUNT_BITS-1:0]   steps_ff, steps_in;
   logic                    sync_found_ff, sync_found_in;
   logic                    ofs_active_ff, ofs_active_in;
   logic [OFS_CNT_BITS-1:0] ofs_count_ff, ofs_count_in;
   logic                    is_open_ff, is_open_in;
   logic [COUNT_BITS-1:0]   elapsed_ff, elapsed_in;

   logic [COUNT_BITS-1:0]   steps_inc;
   logic [COUNT_BITS-1:0]   elapsed_inc;
   logic signed [CMP_W-1:0] diff;
   logic                    hole;
   logic                    arm;
   logic [OFS_CNT_BITS-1:0] ofs_before;
   logic [OFS_CNT_BITS-1:0] ofs_after;
   logic                    open_hit;

   // saturating counters
   assign steps_inc   = (steps_ff == COUNT_MAX) ? steps_ff : steps_ff + 1'b1;
   assign elapsed_inc = (elapsed_ff == COUNT_MAX) ? elapsed_ff : elapsed_ff + 1'b1;

   // hole detection on the two-step rise
   assign diff = $signed(CMP_W'(sample)) - $signed(CMP_W'(older_sample_ff));
   assign hole = (!sync_found_ff || (steps_inc > cfg.min_steps))
              && (diff >= $signed(CMP_W'(cfg.diff_threshold)))
              && (CMP_W'(older_sample_ff) < CMP_W'(cfg.low_trigger));

   // offset counter, restarted by a hole
   assign arm        = hole || ofs_active_ff;
   assign ofs_before = hole ? '0 : ofs_count_ff;
   assign ofs_after  = ofs_before + 1'b1;
   assign open_hit   = arm
      && (((OFS_CMP_W'(ofs_before) == OFS_CMP_W'(cfg.offset_steps)) && cfg.shutter_enable)
          || (ofs_after == OFS_CNT_BITS'(OFFSET_LIMIT)));

   // next state and result
   always_comb begin
      prev_sample_in  = prev_sample_ff;
      older_sample_in = older_sample_ff;
      steps_in        = steps_ff;
      sync_found_in   = sync_found_ff;
      ofs_active_in   = ofs_active_ff;
      ofs_count_in    = ofs_count_ff;
      is_open_in      = is_open_ff;
      elapsed_in      = elapsed_ff;
      result.hole_seen  = 1'b0;
      result.opened_now = 1'b0;
      if (is_open_ff) begin
         if (func == FUNC_TICK) begin
            elapsed_in = elapsed_inc;
            if (elapsed_inc >= cfg.open_time) begin
               is_open_in = 1'b0;
            end
         end
      end else if (func == FUNC_STEP) begin
         steps_in        = steps_inc;
         older_sample_in = prev_sample_ff;
         prev_sample_in  = sample;
         result.hole_seen = hole;
         if (arm) begin
            ofs_active_in = 1'b1;
            ofs_count_in  = ofs_after;
         end
         if (open_hit) begin
            ofs_active_in = 1'b0;
            ofs_count_in  = '0;
            steps_in      = '0;
            sync_found_in = 1'b1;
            is_open_in    = 1'b1;
            elapsed_in    = '0;
            result.opened_now = 1'b1;
         end
      end
      result.shutter_open = is_open_in;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_sample_ff  <= SAMPLE_MID;
         older_sample_ff <= SAMPLE_MID;
         steps_ff        <= '0;
         sync_found_ff   <= 1'b0;
         ofs_active_ff   <= 1'b0;
         ofs_count_ff    <= '0;
         is_open_ff      <= 1'b0;
         elapsed_ff      <= '0;
      end else if (accept) begin
         prev_sample_ff  <= prev_sample_in;
         older_sample_ff <= older_sample_in;
         steps_ff        <= steps_in;
         sync_found_ff   <= sync_found_in;
         ofs_active_ff   <= ofs_active_in;
         ofs_count_ff    <= ofs_count_in;
         is_open_ff      <= is_open_in;
         elapsed_ff      <= elapsed_in;
      end
   end

   // offset counter only runs while the shutter is closed
   assert property (@(posedge clock) disable iff (reset) ofs_active_ff |-> !is_open_ff)
      else $error("offset counter armed while shutter open");

   // an opening transaction leaves the shutter open and the counter idle
   assert property (@(posedge clock) disable iff (reset)
      (accept && result.opened_now) |=> (is_open_ff && !ofs_active_ff && steps_ff == '0))
      else $error("opening did not update state");

   // the counter never passes the forced-open limit
   assert property (@(posedge clock) disable iff (reset)
      ofs_active_ff |-> (ofs_count_ff < OFS_CNT_BITS'(OFFSET_LIMIT)))
      else $error("offset counter beyond limit");

endmodule

[rtl/fsst_rsp_buf.sv]
// two-entry result queue between the update logic and the response channel
module fsst_rsp_buf
   import fsst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       full,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_data
);

   logic [1:0] count_ff, count_in;
   result_type head_ff, head_in;
   result_type tail_ff, tail_in;
   logic       pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign rsp_data  = head_ff;

   // queue update
   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      unique case ({push, pop})
         2'b10: begin
            count_in = count_ff + 2'd1;
            if (count_ff == 2'd0) begin
               head_in = push_data;
            end else begin
               tail_in = push_data;
            end
         end
         2'b01: begin
            count_in = count_ff - 2'd1;
            head_in  = tail_ff;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               head_in = push_data;
            end else begin
               head_in = tail_ff;
               tail_in = push_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("result queue count out of range");

   assert property (@(posedge clock) disable iff (reset) full |-> !push)
      else $error("push into full result queue");

   assert property (@(posedge clock) disable iff (reset)
      (push && count_ff == 2'd0) |=> (rsp_data == $past(push_data)))
      else $error("result queue lost the head entry");

endmodule

[sim/fsst_shutter_checker.sv]
// response checker for the frame sync and shutter timing unit
module fsst_shutter_checker
   import fsst_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic                     req_func,
   input  logic [SAMPLE_BITS-1:0]   req_sample,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic                     rsp_shutter_open,
   input  logic                     rsp_hole_seen,
   input  logic                     rsp_opened_now,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  csr_idx_type              csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output int unsigned              pending_results,
   output int unsigned              fail_count
);

   localparam int REPORT_LIMIT = 10;
   localparam int OFS_WIDTH    = 9;

   // shadow of the register file
   cfg_type cfg;

   // shadow of the frame sync and shutter state
   logic [SAMPLE_BITS-1:0] prev_smp;
   logic [SAMPLE_BITS-1:0] older_smp;
   logic [COUNT_BITS-1:0]  steps_since;
   logic [COUNT_BITS-1:0]  open_ms;
   logic                   synced;
   logic                   armed;
   logic                   shut_open;
   logic [OFS_WIDTH-1:0]   ofs_cnt;

   result_type  expected_shutter_q[$];
   int unsigned mismatches = 0;
   int unsigned rsp_seen   = 0;

   // register write, values cut to the register widths, unknown indexes dropped
   function automatic void load_register(input csr_idx_type idx,
                                         input logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         CSR_OFFSET_STEPS:   cfg.offset_steps   = data[OFFSET_BITS-1:0];
         CSR_DIFF_THRESHOLD: cfg.diff_threshold = data[THRESH_BITS-1:0];
         CSR_LOW_TRIGGER:    cfg.low_trigger    = data[THRESH_BITS-1:0];
         CSR_MIN_STEPS:      cfg.min_steps      = data[COUNT_BITS-1:0];
         CSR_OPEN_TIME:      cfg.open_time      = data[COUNT_BITS-1:0];
         CSR_SHUTTER_ENABLE: cfg.shutter_enable = data[0];
         default: ;
      endcase
   endfunction

   // one step or tick applied to the shadow state, returns the response it must give
   function automatic result_type advance_shutter(input logic func,
                                                  input logic [SAMPLE_BITS-1:0] smp);
      result_type           r;
      int                   rise;
      logic [OFS_WIDTH-1:0] pre_count;
      r = '0;
      if (shut_open) begin
         // steps are ignored while open, ticks run the open timer
         if (func == FUNC_TICK) begin
            if (open_ms != COUNT_MAX)
               open_ms = open_ms + 1'b1;
            if (open_ms >= cfg.open_time)
               shut_open = 1'b0;
         end
      end else if (func == FUNC_STEP) begin
         if (steps_since != COUNT_MAX)
            steps_since = steps_since + 1'b1;
         // hole edge: rise over two steps from a low enough sample
         rise = int'(smp) - int'(older_smp);
         if ((!synced || steps_since > cfg.min_steps) &&
             rise >= int'(cfg.diff_threshold) && older_smp < cfg.low_trigger) begin
            armed       = 1'b1;
            ofs_cnt     = '0;
            r.hole_seen = 1'b1;
         end
         older_smp = prev_smp;
         prev_smp  = smp;
         // offset count toward opening
         if (armed) begin
            pre_count = ofs_cnt;
            ofs_cnt   = ofs_cnt + 1'b1;
            if ((pre_count == OFS_WIDTH'(cfg.offset_steps) && cfg.shutter_enable) ||
                ofs_cnt == OFS_WIDTH'(OFFSET_LIMIT)) begin
               steps_since  = '0;
               synced       = 1'b1;
               shut_open    = 1'b1;
               open_ms      = '0;
               armed        = 1'b0;
               ofs_cnt      = '0;
               r.opened_now = 1'b1;
            end
         end
      end
      r.shutter_open = shut_open;
      return r;
   endfunction

   // watch all three channels
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         cfg.offset_steps   = '0;
         cfg.diff_threshold = THRESH_BITS'(100);
         cfg.low_trigger    = THRESH_BITS'(300);
         cfg.min_steps      = COUNT_BITS'(20);
         cfg.open_time      = COUNT_BITS'(20);
         cfg.shutter_enable = 1'b1;
         prev_smp    = SAMPLE_MID;
         older_smp   = SAMPLE_MID;
         steps_since = '0;
         open_ms     = '0;
         synced      = 1'b0;
         armed       = 1'b0;
         shut_open   = 1'b0;
         ofs_cnt     = '0;
         expected_shutter_q.delete();
      end else begin
         if (csr_valid && csr_ready)
            load_register(csr_index, csr_wdata);
         // predict for each accepted request transaction
         if (req_valid && req_ready)
            expected_shutter_q.push_back(advance_shutter(req_func, req_sample));
         // compare each accepted response transaction with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            got.shutter_open = rsp_shutter_open;
            got.hole_seen    = rsp_hole_seen;
            got.opened_now   = rsp_opened_now;
            if (expected_shutter_q.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("response %0d arrived with nothing expected: open=%b hole=%b opened=%b",
                           rsp_seen, got.shutter_open, got.hole_seen, got.opened_now);
            end else begin
               want = expected_shutter_q.pop_front();
               if (got.shutter_open !== want.shutter_open ||
                   got.hole_seen !== want.hole_seen ||
                   got.opened_now !== want.opened_now) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("response %0d mismatch: expected open=%b hole=%b opened=%b, got open=%b hole=%b opened=%b",
                              rsp_seen, want.shutter_open, want.hole_seen, want.opened_now,
                              got.shutter_open, got.hole_seen, got.opened_now);
               end
            end
            rsp_seen++;
         end
      end
      pending_results <= expected_shutter_q.size();
      fail_count      <= mismatches;
   end

endmodule

[sim/frame_sync_shutter_timing_unit_tb.sv]
// testbench top for the frame sync and shutter timing unit: stimulus and verdict
module frame_sync_shutter_timing_unit_tb;
   import fsst_pkg::*;

   localparam int STALL_CYCLES   = 300;
   localparam int ITEMS_PER_PASS = 220;
   localparam int LONG_FRAMES    = 3;
   localparam int TAIL_CYCLES    = 10;
   localparam int RUN_LIMIT      = 2000000;
   localparam int RESET_CYCLES   = 11;
   localparam int PASSES         = 6;
   localparam csr_idx_type CSR_SPARE_LO = CSR_SHUTTER_ENABLE + 3'd1;
   localparam csr_idx_type CSR_SPARE_HI = '1;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_valid  = 1'b0;
   logic                     req_func   = FUNC_STEP;
   logic [SAMPLE_BITS-1:0]   req_sample = '0;
   logic                     req_ready;
   logic                     rsp_valid;
   logic                     rsp_ready  = 1'b0;
   logic                     rsp_shutter_open;
   logic                     rsp_hole_seen;
   logic                     rsp_opened_now;
   logic                     csr_valid  = 1'b0;
   csr_idx_type              csr_index  = CSR_OFFSET_STEPS;
   logic [CSR_DATA_BITS-1:0] csr_wdata  = '0;
   logic                     csr_ready;

   int unsigned pending_results;
   int unsigned fail_count;

   int unsigned tx_idle_pct = 0;
   int unsigned rx_idle_pct = 0;
   int unsigned stall_asked = 0;
   int unsigned stall_taken = 0;
   int unsigned stall_left  = 0;
   int unsigned items_sent  = 0;

   cfg_type     pass_cfg[PASSES];
   int unsigned pass_tx_idle[PASSES] = '{9, 9, 48, 48, 0, 0};
   int unsigned pass_rx_idle[PASSES] = '{48, 48, 9, 9, 0, 0};

   frame_sync_shutter_timing_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_shutter_open (rsp_shutter_open),
      .rsp_hole_seen    (rsp_hole_seen),
      .rsp_opened_now   (rsp_opened_now),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   fsst_shutter_checker shutter_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_shutter_open (rsp_shutter_open),
      .rsp_hole_seen    (rsp_hole_seen),
      .rsp_opened_now   (rsp_opened_now),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .pending_results  (pending_results),
      .fail_count       (fail_count)
   );

   // clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // response side: random backpressure, or a long hold-off when asked
   always @(posedge clock) begin
      if (stall_asked != stall_taken) begin
         stall_taken <= stall_asked;
         stall_left  <= STALL_CYCLES;
         rsp_ready   <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   function automatic cfg_type make_cfg(input int unsigned ofs, input int unsigned thr,
                                        input int unsigned low, input int unsigned min_gap,
                                        input int unsigned open_len, input int unsigned en);
      cfg_type c;
      c.offset_steps   = OFFSET_BITS'(ofs);
      c.diff_threshold = THRESH_BITS'(thr);
      c.low_trigger    = THRESH_BITS'(low);
      c.min_steps      = COUNT_BITS'(min_gap);
      c.open_time      = COUNT_BITS'(open_len);
      c.shutter_enable = en[0];
      return c;
   endfunction

   // one request transaction, with random gaps ahead of it
   task automatic send_item(input logic func, input logic [SAMPLE_BITS-1:0] smp);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid  <= 1'b0;
         req_sample <= SAMPLE_BITS'($urandom);
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_func   <= func;
      req_sample <= smp;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // stop offering and wait until every predicted response has come back
   task automatic wait_drain;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
   endtask

   task automatic write_csr(input csr_idx_type idx, input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // full register load; unused upper bits carry junk, spare indexes get junk or all ones
   task automatic apply_settings(input cfg_type c);
      logic [CSR_DATA_BITS-1:0] word;
      word = CSR_DATA_BITS'($urandom);
      word[OFFSET_BITS-1:0] = c.offset_steps;
      write_csr(CSR_OFFSET_STEPS, word);
      word = CSR_DATA_BITS'($urandom);
      word[THRESH_BITS-1:0] = c.diff_threshold;
      write_csr(CSR_DIFF_THRESHOLD, word);
      word = CSR_DATA_BITS'($urandom);
      word[THRESH_BITS-1:0] = c.low_trigger;
      write_csr(CSR_LOW_TRIGGER, word);
      write_csr(CSR_MIN_STEPS, c.min_steps);
      write_csr(CSR_OPEN_TIME, c.open_time);
      word = CSR_DATA_BITS'($urandom);
      word[0] = c.shutter_enable;
      write_csr(CSR_SHUTTER_ENABLE, word);
      write_csr(CSR_SPARE_LO, CSR_DATA_BITS'($urandom));
      write_csr(CSR_SPARE_HI, '1);
      csr_valid <= 1'b0;
   endtask

   // one frame (or a short noise burst): quiet low samples, a hole edge, offset steps, then ticks to close
   task automatic send_frame(input cfg_type c);
      int base;
      int rise;
      int n;
      if ($urandom_range(99) < 15) begin
         // noise
         n = $urandom_range(1, 4);
         repeat (n) send_item(1'($urandom_range(1)), SAMPLE_BITS'($urandom));
      end else begin
         if (c.low_trigger == 0 || $urandom_range(4) == 0)
            base = 0;
         else
            base = $urandom_range(c.low_trigger - 1);
         // most edges clear the threshold, some just miss it
         if ($urandom_range(3) == 0)
            rise = base + int'(c.diff_threshold) - 1 - int'($urandom_range(8));
         else
            rise = base + int'(c.diff_threshold) + int'($urandom_range(40));
         if (rise < 0)
            rise = 0;
         if (rise > 1023)
            rise = 1023;
         n = $urandom_range(2, 30);
         repeat (n) send_item(FUNC_STEP, SAMPLE_BITS'(base));
         send_item(FUNC_STEP, SAMPLE_BITS'(rise));
         // steps while the offset counts
         n = $urandom_range(8);
         if ($urandom_range(1))
            n += c.offset_steps;
         if (!c.shutter_enable && $urandom_range(2) == 0)
            n += OFFSET_LIMIT;
         repeat (n) send_item(FUNC_STEP, SAMPLE_BITS'($urandom));
         // ticks with the odd step in between
         n = $urandom_range(2) + ((c.open_time < 40) ? c.open_time : $urandom_range(40));
         repeat (n) begin
            if ($urandom_range(4) == 0)
               send_item(FUNC_STEP, SAMPLE_BITS'($urandom));
            send_item(FUNC_TICK, SAMPLE_BITS'($urandom));
         end
      end
   endtask

   // stimulus
   initial begin
      int unsigned goal;
      bit          paused;
      pass_cfg[0] = make_cfg(5, 100, 300, 20, 3, 1);
      pass_cfg[1] = make_cfg(0, 0, 1023, 0, 0, 1);
      pass_cfg[2] = make_cfg(127, 1023, 1023, 0, 5, 1);
      pass_cfg[3] = make_cfg($urandom_range(127), $urandom_range(300),
                             $urandom_range(1023, 200), $urandom_range(40),
                             $urandom_range(8), 0);
      pass_cfg[4] = make_cfg(10, 200, 500, 5, 2, 0);
      pass_cfg[5] = make_cfg($urandom_range(127), $urandom_range(1023),
                             $urandom_range(1023), $urandom_range(60),
                             $urandom_range(10), 1);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset settings: edge from a low sample opens at once with zero offset
      send_item(FUNC_STEP, '1);
      send_item(FUNC_STEP, '0);
      send_item(FUNC_STEP, '0);
      send_item(FUNC_STEP, '1);
      // step while open is ignored
      send_item(FUNC_STEP, SAMPLE_BITS'(700));
      // open time of 20 ticks, then a tick and a step while closed
      repeat (20) send_item(FUNC_TICK, '1);
      send_item(FUNC_TICK, '0);
      send_item(FUNC_STEP, SAMPLE_BITS'(5));

      // random passes under several settings and idle patterns
      foreach (pass_cfg[p]) begin
         wait_drain;
         tx_idle_pct = pass_tx_idle[p];
         rx_idle_pct <= pass_rx_idle[p];
         apply_settings(pass_cfg[p]);
         if (p == 4)
            stall_asked <= stall_asked + 1;
         goal   = items_sent + ITEMS_PER_PASS;
         paused = 1'b0;
         while (items_sent < goal) begin
            send_frame(pass_cfg[p]);
            if (p == 3 && !paused && items_sent + ITEMS_PER_PASS / 2 >= goal) begin
               wait_drain;
               paused = 1'b1;
            end
         end
      end

      // longest open time and gap
      wait_drain;
      apply_settings(make_cfg(64, 50, 900, 65535, 65535, 1));
      repeat (LONG_FRAMES) send_frame(make_cfg(64, 50, 900, 65535, 65535, 1));

      // drain and verdict
      wait_drain;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // watchdog
   initial begin
      #(RUN_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

endmodule
